// File: rtl/core/dopi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dopi_pkg - shared types and constants of the odometry pose integrator
// Field widths, fixed-point constants, controller states, command and status
// words, and the CORDIC arctangent table in units of 1/2^32 turn.
// ----------------------------------------------------------------------------
package dopi_pkg;

    localparam int PosW     = 32;
    localparam int HeadW    = 16;
    localparam int DistW    = 20;
    localparam int TurnW    = 16;
    localparam int MidW     = HeadW + 1;
    localparam int CordW    = 32;
    localparam int ProdW    = DistW + CordW;
    localparam int FracW    = 30;
    localparam int IncW     = ProdW - FracW;
    localparam int SumW     = PosW + 1;
    localparam int AtanIdxW = 5;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;
    localparam int SDataW   = 40;
    localparam int MDataW   = 80;

    localparam logic signed [CordW-1:0] CordicGain = 32'sd652032874;
    localparam logic signed [ProdW-1:0] HalfQ30    = ProdW'(64'sd536870912);
    localparam logic [MidW-1:0]         MidOffset  = MidW'(16384);
    localparam logic signed [PosW-1:0]  PosMax     = 32'sh7FFF_FFFF;
    localparam logic signed [PosW-1:0]  PosMin     = 32'sh8000_0000;

    typedef enum logic {
        OP_STEP,
        OP_RELOAD
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_START_HEADING
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MUL_X,
        S_ACC_X,
        S_ACC_Y,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic reload;
        logic rotate;
        logic mul_en;
        logic mul_sel_y;
        logic acc_x;
        logic acc_y;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic rot_last;
    } t_status;

    function automatic logic signed [CordW-1:0] atan_turn(input logic [AtanIdxW-1:0] idx);
        logic signed [CordW-1:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/dopi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dopi_ctrl - sequencer of the odometry pose integrator
// Accepts one word at a time and steps the datapath through CORDIC rotation,
// two multiply and accumulate steps and the result capture (a reload goes straight to capture).
// ----------------------------------------------------------------------------
module dopi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire dopi_pkg::t_op     i_op,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire dopi_pkg::t_status i_status,
    output dopi_pkg::t_cmd         o_cmd
);

    dopi_pkg::t_state r_state;
    dopi_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dopi_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_op == dopi_pkg::OP_RELOAD) ? dopi_pkg::S_DONE
                                                            : dopi_pkg::S_ROT;
                end
            end
            dopi_pkg::S_ROT: begin
                if (i_status.rot_last) begin
                    n_state = dopi_pkg::S_MUL_X;
                end
            end
            dopi_pkg::S_MUL_X: n_state = dopi_pkg::S_ACC_X;
            dopi_pkg::S_ACC_X: n_state = dopi_pkg::S_ACC_Y;
            dopi_pkg::S_ACC_Y: n_state = dopi_pkg::S_DONE;
            dopi_pkg::S_DONE: begin
                if (slot_free) begin
                    n_state = dopi_pkg::S_IDLE;
                end
            end
            default: n_state = dopi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            dopi_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.load   = i_s_tvalid;
                o_cmd.reload = i_s_tvalid && (i_op == dopi_pkg::OP_RELOAD);
            end
            dopi_pkg::S_ROT: o_cmd.rotate = 1'b1;
            dopi_pkg::S_MUL_X: o_cmd.mul_en = 1'b1;
            dopi_pkg::S_ACC_X: begin
                o_cmd.acc_x     = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel_y = 1'b1;
            end
            dopi_pkg::S_ACC_Y: o_cmd.acc_y = 1'b1;
            dopi_pkg::S_DONE: o_cmd.capture = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dopi_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/core/dopi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dopi_dp - datapath of the odometry pose integrator
// Start pose registers, pose state, iterative CORDIC, shared multiplier,
// saturating accumulator and the result register.
// ----------------------------------------------------------------------------
module dopi_dp #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dopi_pkg::CfgIdxW-1:0]          i_cfg_idx,
    input  wire logic [dopi_pkg::CfgDataW-1:0]         i_cfg_data,
    input  wire logic signed [dopi_pkg::DistW-1:0]     i_step_distance,
    input  wire logic signed [dopi_pkg::TurnW-1:0]     i_step_turn,
    input  wire dopi_pkg::t_cmd                        i_cmd,
    output dopi_pkg::t_status                          o_status,
    output logic signed [dopi_pkg::PosW-1:0]           o_pos_x,
    output logic signed [dopi_pkg::PosW-1:0]           o_pos_y,
    output logic [dopi_pkg::HeadW-1:0]                 o_heading,
    output logic                                       o_saturated
);

    localparam int IterW = $clog2(CORDIC_ITERATIONS);

    logic signed [dopi_pkg::PosW-1:0]  r_start_x;
    logic signed [dopi_pkg::PosW-1:0]  r_start_y;
    logic [dopi_pkg::HeadW-1:0]        r_start_heading;

    logic signed [dopi_pkg::PosW-1:0]  r_pos_x;
    logic signed [dopi_pkg::PosW-1:0]  r_pos_y;
    logic [dopi_pkg::HeadW-1:0]        r_heading;
    logic                              r_sat;

    logic signed [dopi_pkg::DistW-1:0] r_dist;
    logic [dopi_pkg::HeadW-1:0]        r_turn;
    logic [1:0]                        r_quad;
    logic [IterW-1:0]                  r_iter;
    logic signed [dopi_pkg::CordW-1:0] r_cx;
    logic signed [dopi_pkg::CordW-1:0] r_cy;
    logic signed [dopi_pkg::CordW-1:0] r_cz;
    logic signed [dopi_pkg::ProdW-1:0] r_prod;

    logic signed [dopi_pkg::PosW-1:0]  r_out_x;
    logic signed [dopi_pkg::PosW-1:0]  r_out_y;
    logic [dopi_pkg::HeadW-1:0]        r_out_heading;
    logic                              r_out_sat;

    logic [dopi_pkg::MidW-1:0]         mid;
    logic signed [dopi_pkg::CordW-1:0] z_init;
    logic signed [dopi_pkg::CordW-1:0] dx;
    logic signed [dopi_pkg::CordW-1:0] dy;
    logic signed [dopi_pkg::CordW-1:0] atan_val;
    logic signed [dopi_pkg::CordW-1:0] cos_v;
    logic signed [dopi_pkg::CordW-1:0] sin_v;
    logic signed [dopi_pkg::CordW-1:0] mul_op;
    logic signed [dopi_pkg::ProdW-1:0] rounded;
    logic signed [dopi_pkg::IncW-1:0]  inc;
    logic signed [dopi_pkg::PosW-1:0]  acc_base;
    logic signed [dopi_pkg::SumW-1:0]  sum;
    logic signed [dopi_pkg::PosW-1:0]  acc_val;
    logic                              acc_clip;
    logic [dopi_pkg::HeadW-1:0]        n_heading;

    // midpoint angle in 1/2^17 turn, offset by an eighth turn for the quadrant split
    assign mid    = {r_heading, 1'b0} + {i_step_turn[dopi_pkg::TurnW-1], i_step_turn}
                  + dopi_pkg::MidOffset;
    assign z_init = {{3{~mid[14]}}, mid[13:0], 15'd0};

    assign dx       = r_cy >>> r_iter;
    assign dy       = r_cx >>> r_iter;
    assign atan_val = dopi_pkg::atan_turn(dopi_pkg::AtanIdxW'(r_iter));

    assign o_status.rot_last = (r_iter == IterW'(CORDIC_ITERATIONS - 1));

    always_comb begin
        case (r_quad)
            2'd0: begin
                cos_v = r_cx;
                sin_v = r_cy;
            end
            2'd1: begin
                cos_v = -r_cy;
                sin_v = r_cx;
            end
            2'd2: begin
                cos_v = -r_cx;
                sin_v = -r_cy;
            end
            default: begin
                cos_v = r_cy;
                sin_v = -r_cx;
            end
        endcase
    end

    assign mul_op   = i_cmd.mul_sel_y ? sin_v : cos_v;
    assign rounded  = r_prod + dopi_pkg::HalfQ30;
    assign inc      = rounded[dopi_pkg::ProdW-1:dopi_pkg::FracW];
    assign acc_base = i_cmd.acc_y ? r_pos_y : r_pos_x;
    assign sum      = {acc_base[dopi_pkg::PosW-1], acc_base}
                    + {{(dopi_pkg::SumW - dopi_pkg::IncW){inc[dopi_pkg::IncW-1]}}, inc};

    always_comb begin
        acc_clip = sum[dopi_pkg::SumW-1] != sum[dopi_pkg::SumW-2];
        if (!acc_clip) begin
            acc_val = sum[dopi_pkg::PosW-1:0];
        end else if (sum[dopi_pkg::SumW-1]) begin
            acc_val = dopi_pkg::PosMin;
        end else begin
            acc_val = dopi_pkg::PosMax;
        end
    end

    assign n_heading = r_heading + r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dopi_pkg::CFG_START_X:       r_start_x       <= i_cfg_data;
                dopi_pkg::CFG_START_Y:       r_start_y       <= i_cfg_data;
                dopi_pkg::CFG_START_HEADING: r_start_heading <= i_cfg_data[dopi_pkg::HeadW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_sat     <= 1'b0;
        end else if (i_cmd.reload) begin
            r_pos_x   <= r_start_x;
            r_pos_y   <= r_start_y;
            r_heading <= r_start_heading;
            r_sat     <= 1'b0;
        end else if (i_cmd.load) begin
            r_sat <= 1'b0;
        end else if (i_cmd.acc_x) begin
            r_pos_x <= acc_val;
            r_sat   <= r_sat | acc_clip;
        end else if (i_cmd.acc_y) begin
            r_pos_y <= acc_val;
            r_sat   <= r_sat | acc_clip;
        end else if (i_cmd.capture) begin
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dist <= i_step_distance;
            r_turn <= i_cmd.reload ? '0 : i_step_turn;
            r_quad <= mid[16:15];
            r_iter <= '0;
            r_cx   <= dopi_pkg::CordicGain;
            r_cy   <= '0;
            r_cz   <= z_init;
        end else if (i_cmd.rotate) begin
            r_iter <= r_iter + 1'b1;
            if (!r_cz[dopi_pkg::CordW-1]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - atan_val;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + atan_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_dist * mul_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_x       <= r_pos_x;
            r_out_y       <= r_pos_y;
            r_out_heading <= n_heading;
            r_out_sat     <= r_sat;
        end
    end

    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_heading;
    assign o_saturated = r_out_sat;

endmodule
`default_nettype wire

// File: rtl/core/differential_odometry_pose_integrator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_odometry_pose_integrator_top - dead-reckoning pose integrator
// Integrates distance and heading change of a two-wheeled robot at the
// midpoint heading and keeps a saturating x, y position and a wrapping heading.
//
// Usage:
//   Slave stream takes one word per step: tuser selects step or reload,
//   tdata carries distance and heading change. Master stream returns one
//   word per input word with the updated pose and a clip flag in tuser.
//   The user writes the start pose registers through the cfg port only
//   while idle; the block itself does not enforce this. A step runs the
//   one-rotation-per-cycle CORDIC loop and then the shared multiplier for x
//   then y. A reload skips the rotation and the multiplier.
//   One word is in work at a time; s_tready is high only while idle.
//   The result register holds its word while m_tready is low; a following
//   word is accepted and computed, and waits before capture until the
//   register is free.
//   Reset clears the pose and the start registers to zero.
// ----------------------------------------------------------------------------
module differential_odometry_pose_integrator_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dopi_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire logic [dopi_pkg::CfgDataW-1:0]     i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [19:0] step_distance, [35:20] step_turn, [39:36] zero
    input  wire logic [dopi_pkg::SDataW-1:0]       s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
    output logic [dopi_pkg::MDataW-1:0]            m_axis_tdata,
    // [0] saturated
    output logic [0:0]                             m_axis_tuser
);

    dopi_pkg::t_cmd                    cmd;
    dopi_pkg::t_status                 status;
    logic signed [dopi_pkg::PosW-1:0]  pos_x;
    logic signed [dopi_pkg::PosW-1:0]  pos_y;
    logic [dopi_pkg::HeadW-1:0]        heading;
    logic                              saturated;

    dopi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (dopi_pkg::t_op'(s_axis_tuser[0])),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dopi_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_step_distance (s_axis_tdata[19:0]),
        .i_step_turn     (s_axis_tdata[35:20]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_heading       (heading),
        .o_saturated     (saturated)
    );

    assign m_axis_tdata = {heading, pos_y, pos_x};
    assign m_axis_tuser = saturated;

endmodule
`default_nettype wire
